### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the telemetry batch parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every rising edge outside reset.
`define TBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check an implication on every rising edge, reset included.
`define TBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, codes and the encoding size table of the telemetry batch parser.
// ----------------------------------------------------------------------------
package tbp_pkg;

    localparam int MAX_SAMPLES_DEF = 64;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_TOO_SHORT = 2'd0;
    localparam logic [1:0] ERR_BAD_COUNT = 2'd1;
    localparam logic [1:0] ERR_BAD_ENC   = 2'd2;
    localparam logic [1:0] ERR_TRUNCATED = 2'd3;

    localparam logic [2:0] HDR_LAST_POS  = 3'd5;
    localparam logic [2:0] HDR_COUNT_POS = 3'd4;
    localparam logic [2:0] SMP_ENC_POS   = 3'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_payload;
    } t_in;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] base_timestamp;
        logic [7:0]  batch_flags;
        logic [6:0]  sample_count;
        logic [7:0]  channel;
        logic [15:0] delta_ms;
        logic [2:0]  encoding;
        logic [31:0] value_bits;
        logic [2:0]  value_length;
        logic [5:0]  sample_number;
        logic        final_sample;
        logic [1:0]  error_code;
    } t_out;

    function automatic logic [2:0] enc_size(input logic [2:0] enc);
        logic [2:0] sz;
        case (enc)
            3'd0:    sz = 3'd1;
            3'd1:    sz = 3'd1;
            3'd2:    sz = 3'd2;
            3'd3:    sz = 3'd2;
            3'd4:    sz = 3'd4;
            3'd5:    sz = 3'd4;
            3'd6:    sz = 3'd4;
            default: sz = 3'd1;
        endcase
        return sz;
    endfunction

endpackage

### rtl/telemetry_batch_parser_top.sv
// ----------------------------------------------------------------------------
// telemetry_batch_parser_top
// Parses a byte-serial telemetry batch: header, samples and error results.
// ----------------------------------------------------------------------------
//  channel  direction  payload  handshake
//  input    in         t_in     i_valid / o_stall
//  output   out        t_out    o_valid / i_stall
//
//  One byte per cycle while o_stall is low; its results land in a three-entry
//  result queue on the edge that takes the byte, and leave it one per cycle
//  while i_stall is low. A byte gives at most two results; the queue takes
//  a byte while it holds at most one result, so a byte with two results
//  stalls the input even when the output does not stall; otherwise bytes
//  flow every cycle. Synchronous active-low reset returns the parser to
//  the header phase and empties the queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module telemetry_batch_parser_top #(
    parameter int MAX_SAMPLES = tbp_pkg::MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tbp_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output tbp_pkg::t_out o_data
);
    import tbp_pkg::*;

    localparam logic [7:0] MaxCount = 8'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'b001,
        PH_SAMPLES = 3'b010,
        PH_DONE    = 3'b100
    } t_phase;

    t_phase      r_phase,    n_phase;
    logic [2:0]  r_pos,      n_pos;
    logic [7:0]  r_count_a,  n_count_a;
    logic [7:0]  r_seen,     n_seen;
    logic [31:0] r_ts,       n_ts;
    logic [7:0]  r_flags,    n_flags;
    logic [7:0]  r_chan,     n_chan;
    logic [15:0] r_delta,    n_delta;
    logic [2:0]  r_enc,      n_enc;
    logic [31:0] r_value,    n_value;

    t_out        r_q [3];
    t_out        n_q [3];
    logic [1:0]  r_qcnt,     n_qcnt;

    logic        in_xfer;
    logic        out_xfer;
    t_out        res_a;
    t_out        res_b;
    logic [1:0]  nres;
    logic [1:0]  base;
    logic        last;
    logic [2:0]  vcnt;

    function automatic t_out mk_error(input logic [1:0] code);
        t_out r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        return r;
    endfunction

    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;
    assign o_stall  = (r_qcnt > 2'd1);
    assign o_valid  = (r_qcnt != 2'd0);
    assign o_data   = r_q[0];

    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_count_a = r_count_a;
        n_seen    = r_seen;
        n_ts      = r_ts;
        n_flags   = r_flags;
        n_chan    = r_chan;
        n_delta   = r_delta;
        n_enc     = r_enc;
        n_value   = r_value;
        res_a     = '0;
        res_b     = '0;
        nres      = 2'd0;
        last      = 1'b0;
        vcnt      = 3'(r_pos - SMP_ENC_POS);
        if (in_xfer) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos < HDR_COUNT_POS) begin
                        n_ts = r_ts | ({24'd0, i_data.data_byte} << {r_pos[1:0], 3'b000});
                    end else if (r_pos == HDR_COUNT_POS) begin
                        n_count_a = i_data.data_byte;
                    end else begin
                        n_flags = i_data.data_byte;
                    end
                    if (r_pos >= HDR_LAST_POS) begin
                        if (r_count_a == 8'd0 || r_count_a > MaxCount) begin
                            res_a   = mk_error(ERR_BAD_COUNT);
                            nres    = 2'd1;
                            n_phase = PH_DONE;
                        end else begin
                            res_a.kind           = KIND_HEADER;
                            res_a.base_timestamp = r_ts;
                            res_a.batch_flags    = i_data.data_byte;
                            res_a.sample_count   = r_count_a[6:0];
                            nres    = 2'd1;
                            n_phase = PH_SAMPLES;
                            n_pos   = 3'd0;
                            n_seen  = 8'd0;
                            if (i_data.end_of_payload) begin
                                res_b = mk_error(ERR_TRUNCATED);
                                nres  = 2'd2;
                            end
                        end
                    end else begin
                        n_pos = r_pos + 3'd1;
                        if (i_data.end_of_payload) begin
                            res_a = mk_error(ERR_TOO_SHORT);
                            nres  = 2'd1;
                        end
                    end
                end
                PH_SAMPLES: begin
                    if (r_pos == 3'd0) begin
                        n_chan = i_data.data_byte;
                        n_pos  = r_pos + 3'd1;
                    end else if (r_pos == 3'd1) begin
                        n_delta = {8'd0, i_data.data_byte};
                        n_pos   = r_pos + 3'd1;
                    end else if (r_pos == 3'd2) begin
                        n_delta = r_delta | {i_data.data_byte, 8'd0};
                        n_pos   = r_pos + 3'd1;
                    end else if (r_pos == SMP_ENC_POS) begin
                        if (i_data.data_byte >= 8'd8) begin
                            res_a   = mk_error(ERR_BAD_ENC);
                            nres    = 2'd1;
                            n_phase = PH_DONE;
                        end else begin
                            n_enc   = i_data.data_byte[2:0];
                            n_value = 32'd0;
                            n_pos   = r_pos + 3'd1;
                        end
                    end else begin
                        n_value = r_value
                                | ({24'd0, i_data.data_byte} << {r_pos[1:0], 3'b000});
                        if (vcnt >= enc_size(r_enc)) begin
                            last                 = (8'(r_seen + 8'd1) == r_count_a);
                            res_a.kind           = KIND_SAMPLE;
                            res_a.sample_count   = r_count_a[6:0];
                            res_a.channel        = r_chan;
                            res_a.delta_ms       = r_delta;
                            res_a.encoding       = r_enc;
                            res_a.value_bits     = n_value;
                            res_a.value_length   = enc_size(r_enc);
                            res_a.sample_number  = r_seen[5:0];
                            res_a.final_sample   = last;
                            nres   = 2'd1;
                            n_seen = r_seen + 8'd1;
                            n_pos  = 3'd0;
                            if (last) begin
                                n_phase = PH_DONE;
                            end
                        end else begin
                            n_pos = r_pos + 3'd1;
                        end
                    end
                    if (i_data.end_of_payload && n_phase == PH_SAMPLES) begin
                        if (nres == 2'd0) begin
                            res_a = mk_error(ERR_TRUNCATED);
                        end else begin
                            res_b = mk_error(ERR_TRUNCATED);
                        end
                        nres = nres + 2'd1;
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_HEADER;
                end
            endcase
            if (i_data.end_of_payload) begin
                n_phase   = PH_HEADER;
                n_pos     = 3'd0;
                n_count_a = 8'd0;
                n_seen    = 8'd0;
                n_ts      = 32'd0;
                n_flags   = 8'd0;
                n_chan    = 8'd0;
                n_delta   = 16'd0;
                n_enc     = 3'd0;
                n_value   = 32'd0;
            end
        end
    end

    always_comb begin
        base = r_qcnt - {1'b0, out_xfer};
        for (int k = 0; k < 3; k++) begin
            n_q[k] = r_q[k];
            if (out_xfer && k < 2) begin
                n_q[k] = r_q[k + 1];
            end
            if (nres != 2'd0 && 2'(k) == base) begin
                n_q[k] = res_a;
            end
            if (nres == 2'd2 && 2'(k) == 2'(base + 2'd1)) begin
                n_q[k] = res_b;
            end
        end
        n_qcnt = base + nres;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_pos     <= 3'd0;
            r_count_a <= 8'd0;
            r_seen    <= 8'd0;
            r_ts      <= 32'd0;
            r_flags   <= 8'd0;
            r_chan    <= 8'd0;
            r_delta   <= 16'd0;
            r_enc     <= 3'd0;
            r_value   <= 32'd0;
            r_qcnt    <= 2'd0;
        end else begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_count_a <= n_count_a;
            r_seen    <= n_seen;
            r_ts      <= n_ts;
            r_flags   <= n_flags;
            r_chan    <= n_chan;
            r_delta   <= n_delta;
            r_enc     <= n_enc;
            r_value   <= n_value;
            r_qcnt    <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    `TBP_ASSERT(a_queue_bound, i_clk, i_rst_n, r_qcnt != 2'd3 || !in_xfer, "transfer into full result queue")
    `TBP_ASSERT(a_eop_restart, i_clk, i_rst_n, in_xfer && i_data.end_of_payload |=> r_phase == PH_HEADER && r_pos == 3'd0, "end of payload did not restart header phase")
    `TBP_ASSERT(a_done_silent, i_clk, i_rst_n, in_xfer && r_phase == PH_DONE |=> r_qcnt <= $past(r_qcnt), "ignored byte produced a result")
    `TBP_ASSERT(a_sample_len, i_clk, i_rst_n, o_valid && o_data.kind == KIND_SAMPLE |-> o_data.value_length != 3'd0, "sample result without value length")

endmodule

### dv/tb_telemetry_batch_parser_top.sv
// ----------------------------------------------------------------------------
// tb_telemetry_batch_parser_top
// Self-checking bench for the telemetry batch parser. A queue-fed driver
// sends payload bytes, and a monitor tracks a software copy of the parse
// state. The monitor builds the expected header, sample and error results
// and compares each output transfer field by field. Stimulus runs in four
// parts: a directed set of corner payloads, a burst with no idling, a long
// output hold-off that backs the block up, and a long randomized run with
// random idling on both sides.
// ----------------------------------------------------------------------------
module tb_telemetry_batch_parser_top;

    import tbp_pkg::*;

    localparam int MAX_COUNT      = MAX_SAMPLES_DEF;
    localparam int HOLDOFF_CYCLES = 300;

    localparam logic [2:0] VALUE_BYTES [8] = '{3'd1, 3'd1, 3'd2, 3'd2,
                                               3'd4, 3'd4, 3'd4, 3'd1};

    typedef enum logic [2:0] {
        IN_HEADER  = 3'b001,
        IN_SAMPLES = 3'b010,
        SKIPPING   = 3'b100
    } t_parse_phase;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_in   i_data  = '0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_out  o_data;

    t_in   payload_bytes[$];
    t_out  pending_results[$];
    int    bytes_planned  = 0;
    int    mismatch_count = 0;
    bit    idle_en        = 1'b1;
    bit    holdoff_req    = 1'b0;
    bit    holdoff_done;
    int    holdoff_left;

    t_parse_phase rx_phase;
    logic [2:0]   rx_pos;
    logic [7:0]   hdr_count;
    logic [7:0]   smp_seen;
    logic [31:0]  hdr_stamp;
    logic [7:0]   hdr_flags;
    logic [7:0]   smp_channel;
    logic [15:0]  smp_delta;
    logic [2:0]   smp_enc;
    logic [31:0]  smp_value;

    telemetry_batch_parser_top #(
        .MAX_SAMPLES(MAX_COUNT)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic void clear_parser();
        rx_phase    = IN_HEADER;
        rx_pos      = '0;
        hdr_count   = '0;
        smp_seen    = '0;
        hdr_stamp   = '0;
        hdr_flags   = '0;
        smp_channel = '0;
        smp_delta   = '0;
        smp_enc     = '0;
        smp_value   = '0;
    endfunction

    function automatic void emit_error(input logic [1:0] code);
        t_out r;
        r            = '0;
        r.kind       = KIND_ERROR;
        r.error_code = code;
        pending_results.push_back(r);
    endfunction

    function automatic void parse_byte(input t_in item);
        t_out       r;
        logic [7:0] b;
        bit         eop;
        bit         sample_done;
        bit         last;
        b           = item.data_byte;
        eop         = item.end_of_payload;
        sample_done = 1'b0;
        case (rx_phase)
            IN_HEADER: begin
                if (rx_pos < HDR_COUNT_POS) begin
                    hdr_stamp |= 32'(b) << (8 * int'(rx_pos));
                end else if (rx_pos == HDR_COUNT_POS) begin
                    hdr_count = b;
                end else begin
                    hdr_flags = b;
                end
                if (rx_pos >= HDR_LAST_POS) begin
                    if (hdr_count < 1 || int'(hdr_count) > MAX_COUNT) begin
                        emit_error(ERR_BAD_COUNT);
                        rx_phase = SKIPPING;
                    end else begin
                        r                = '0;
                        r.kind           = KIND_HEADER;
                        r.base_timestamp = hdr_stamp;
                        r.batch_flags    = hdr_flags;
                        r.sample_count   = hdr_count[6:0];
                        pending_results.push_back(r);
                        rx_phase = IN_SAMPLES;
                        rx_pos   = '0;
                        smp_seen = '0;
                        if (eop) begin
                            emit_error(ERR_TRUNCATED);
                        end
                    end
                end else begin
                    rx_pos++;
                    if (eop) begin
                        emit_error(ERR_TOO_SHORT);
                    end
                end
            end
            IN_SAMPLES: begin
                if (rx_pos == 3'd0) begin
                    smp_channel = b;
                end else if (rx_pos == 3'd1) begin
                    smp_delta = {8'h00, b};
                end else if (rx_pos == 3'd2) begin
                    smp_delta[15:8] = b;
                end else if (rx_pos == SMP_ENC_POS) begin
                    if (b >= 8) begin
                        emit_error(ERR_BAD_ENC);
                        rx_phase = SKIPPING;
                    end else begin
                        smp_enc   = b[2:0];
                        smp_value = '0;
                    end
                end else begin
                    smp_value |= 32'(b) << (8 * (int'(rx_pos) - 4));
                    if (int'(rx_pos) - 3 >= int'(VALUE_BYTES[smp_enc])) begin
                        sample_done = 1'b1;
                    end
                end
                if (rx_phase == IN_SAMPLES) begin
                    if (sample_done) begin
                        last            = (int'(smp_seen) + 1 == int'(hdr_count));
                        r               = '0;
                        r.kind          = KIND_SAMPLE;
                        r.sample_count  = hdr_count[6:0];
                        r.channel       = smp_channel;
                        r.delta_ms      = smp_delta;
                        r.encoding      = smp_enc;
                        r.value_bits    = smp_value;
                        r.value_length  = VALUE_BYTES[smp_enc];
                        r.sample_number = smp_seen[5:0];
                        r.final_sample  = last;
                        pending_results.push_back(r);
                        smp_seen++;
                        rx_pos = '0;
                        if (last) begin
                            rx_phase = SKIPPING;
                        end
                    end else begin
                        rx_pos++;
                    end
                    if (eop && rx_phase == IN_SAMPLES) begin
                        emit_error(ERR_TRUNCATED);
                    end
                end
            end
            default: begin
            end
        endcase
        if (eop) begin
            clear_parser();
        end
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_result(input t_out got, input t_out want);
        check_field("kind", want.kind, got.kind);
        check_field("base_timestamp", want.base_timestamp, got.base_timestamp);
        check_field("batch_flags", want.batch_flags, got.batch_flags);
        check_field("sample_count", want.sample_count, got.sample_count);
        check_field("channel", want.channel, got.channel);
        check_field("delta_ms", want.delta_ms, got.delta_ms);
        check_field("encoding", want.encoding, got.encoding);
        check_field("value_bits", want.value_bits, got.value_bits);
        check_field("value_length", want.value_length, got.value_length);
        check_field("sample_number", want.sample_number, got.sample_number);
        check_field("final_sample", want.final_sample, got.final_sample);
        check_field("error_code", want.error_code, got.error_code);
    endfunction

    function automatic void push_byte(input logic [7:0] b, input bit eop);
        t_in item;
        item.data_byte      = b;
        item.end_of_payload = eop;
        payload_bytes.push_back(item);
        bytes_planned++;
    endfunction

    function automatic void push_header(input logic [31:0] stamp, input logic [7:0] count,
                                        input logic [7:0] flags, input bit eop);
        for (int i = 0; i < 4; i++) begin
            push_byte(stamp[8*i +: 8], 1'b0);
        end
        push_byte(count, 1'b0);
        push_byte(flags, eop);
    endfunction

    function automatic void add_payload();
        logic [7:0]  bytes[$];
        logic [31:0] stamp;
        logic [7:0]  enc;
        int          count;
        int          mode;
        int          bad_at;
        int          cut;
        mode  = $urandom_range(99);
        stamp = $urandom();
        if (mode >= 95) begin
            repeat ($urandom_range(12, 1)) begin
                push_byte(8'($urandom_range(255)), $urandom_range(5) == 0);
            end
            push_byte(8'($urandom_range(255)), 1'b1);
            return;
        end
        if (mode >= 88) begin
            count = ($urandom_range(1) == 0) ? 0 : $urandom_range(255, MAX_COUNT + 1);
        end else if ($urandom_range(39) == 0) begin
            count = MAX_COUNT;
        end else if ($urandom_range(9) == 0) begin
            count = $urandom_range(16, 5);
        end else begin
            count = $urandom_range(4, 1);
        end
        bad_at = (mode >= 81 && mode < 88) ? $urandom_range(count - 1) : -1;
        for (int i = 0; i < 4; i++) begin
            bytes.push_back(stamp[8*i +: 8]);
        end
        bytes.push_back(count[7:0]);
        bytes.push_back(8'($urandom_range(255)));
        if (mode < 88) begin
            for (int s = 0; s < count; s++) begin
                enc = (s == bad_at) ? 8'($urandom_range(255, 8)) : 8'($urandom_range(7));
                bytes.push_back(8'($urandom_range(255)));
                bytes.push_back(8'($urandom_range(255)));
                bytes.push_back(8'($urandom_range(255)));
                bytes.push_back(enc);
                if (s == bad_at) begin
                    break;
                end
                repeat (VALUE_BYTES[enc[2:0]]) begin
                    bytes.push_back(8'($urandom_range(255)));
                end
            end
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(3, 1)) begin
                bytes.push_back(8'($urandom_range(255)));
            end
        end
        if (mode >= 70 && mode < 81) begin
            cut = $urandom_range(bytes.size() - 1, 1);
            bytes = bytes[0:cut-1];
        end
        foreach (bytes[i]) begin
            push_byte(bytes[i], i == bytes.size() - 1);
        end
    endfunction

    task automatic wait_idle();
        while (payload_bytes.size() != 0 || i_valid || pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data  <= '0;
        end else if (!i_valid || !o_stall) begin
            if (payload_bytes.size() != 0 && !(idle_en && $urandom_range(99) < 9)) begin
                i_data  <= payload_bytes.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall      <= 1'b0;
            holdoff_left <= 0;
            holdoff_done <= 1'b0;
            clear_parser();
            pending_results.delete();
        end else begin
            if (i_valid && !o_stall) begin
                parse_byte(i_data);
            end
            if (o_valid && !i_stall) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result transfer, kind %0d", o_data.kind);
                    mismatch_count++;
                end else begin
                    compare_result(o_data, pending_results.pop_front());
                end
            end
            if (holdoff_req && !holdoff_done) begin
                holdoff_done <= 1'b1;
                holdoff_left <= HOLDOFF_CYCLES;
                i_stall      <= 1'b1;
            end else if (holdoff_left != 0) begin
                holdoff_left <= holdoff_left - 1;
                i_stall      <= 1'b1;
            end else begin
                i_stall <= idle_en && ($urandom_range(99) < 9);
            end
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_byte(8'h00, 1'b1);
        push_header(32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b1);
        push_header(32'h0000_0000, 8'd1, 8'h00, 1'b1);
        push_header(32'h1234_5678, 8'(MAX_COUNT + 1), 8'h5A, 1'b0);
        push_byte(8'hA5, 1'b1);
        push_header(32'h8000_0001, 8'(MAX_COUNT), 8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        wait_idle();

        idle_en = 1'b0;
        while (bytes_planned < 300) begin
            add_payload();
        end
        wait_idle();

        holdoff_req = 1'b1;
        while (bytes_planned < 450) begin
            add_payload();
        end
        wait_idle();

        idle_en = 1'b1;
        while (bytes_planned < 1000) begin
            add_payload();
        end
        wait_idle();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("Mismatches found");
        $finish;
    end

endmodule
